// ===== src/tip_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tip_pkg
// Shared types and constants for the ternarizing im2row packer.
// ============================================================================
package tip_pkg;

  // Default store geometry, handed to the top level parameters
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_BLOCKS_DEF = 4;

  // Channels per packed word pair
  localparam int WORD_BITS = 64;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Stream payload widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 2 * WORD_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_PAD_ROWS      = 3'd1,
    CFG_PAD_COLS      = 3'd2,
    CFG_ROW_STRIDE    = 3'd3,
    CFG_COL_STRIDE    = 3'd4,
    CFG_IMAGE_ROWS    = 3'd5,
    CFG_IMAGE_COLS    = 3'd6,
    CFG_CHANNEL_COUNT = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    logic [14:0] threshold;
    logic [2:0]  pad_rows;
    logic [2:0]  pad_cols;
    logic [2:0]  row_stride;
    logic [2:0]  col_stride;
    logic [6:0]  image_rows;
    logic [6:0]  image_cols;
    logic [8:0]  channel_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold:     15'd0,
    pad_rows:      3'd0,
    pad_cols:      3'd0,
    row_stride:    3'd1,
    col_stride:    3'd1,
    image_rows:    7'd64,
    image_cols:    7'd64,
    channel_count: 9'd64
  };

  // One classified item on its way to the back end.
  // For a write, mask is the one-hot channel bit; for a read it is the
  // channel mask applied to the fetched words (zero for padding).
  typedef struct packed {
    op_e                  op;
    logic                 padded;
    logic                 neg_bit;
    logic                 nz_bit;
    logic [WORD_BITS-1:0] mask;
  } cmd_t;

endpackage

// ===== src/tip_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tip_front
// Holds the configuration registers and classifies incoming beats into
// store writes or window reads with their address and channel mask.
// ============================================================================
module tip_front #(
  parameter int MAX_ROWS   = tip_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = tip_pkg::MAX_COLS_DEF,
  parameter int MAX_BLOCKS = tip_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_W     = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         req_type_i,
  input  logic [15:0]                  sample_i,
  input  logic [5:0]                   pixel_row_i,
  input  logic [5:0]                   pixel_col_i,
  input  logic [7:0]                   channel_i,
  input  logic [6:0]                   out_row_i,
  input  logic [6:0]                   out_col_i,
  input  logic [3:0]                   kernel_row_i,
  input  logic [3:0]                   kernel_col_i,
  input  logic [1:0]                   block_i,
  output tip_pkg::cmd_t                cmd_o,
  output logic [ADDR_W-1:0]            addr_o,
  output logic                         keep_o
);
  import tip_pkg::*;

  localparam int CH_LIM = MAX_BLOCKS * WORD_BITS;

  cfg_t cfg_q, cfg_d;

  logic [6:0] rows, cols;
  logic [8:0] chans;

  logic signed [16:0] s_ext, t_pos, t_neg;
  logic               ld_in_range;
  logic [ADDR_W-1:0]  ld_addr;

  logic [9:0]           ph, pw, rows_hi, cols_hi, r_off, c_off, rem;
  logic                 rd_pad, blk_used, rd_use;
  logic [3:0]           nblk;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] part_mask;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:     cfg_d.threshold     = cfg_data_i[14:0];
        CFG_PAD_ROWS:      cfg_d.pad_rows      = cfg_data_i[2:0];
        CFG_PAD_COLS:      cfg_d.pad_cols      = cfg_data_i[2:0];
        CFG_ROW_STRIDE:    cfg_d.row_stride    = cfg_data_i[2:0];
        CFG_COL_STRIDE:    cfg_d.col_stride    = cfg_data_i[2:0];
        CFG_IMAGE_ROWS:    cfg_d.image_rows    = cfg_data_i[6:0];
        CFG_IMAGE_COLS:    cfg_d.image_cols    = cfg_data_i[6:0];
        CFG_CHANNEL_COUNT: cfg_d.channel_count = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sizes in use, limited to the store geometry
  assign rows  = (int'(cfg_q.image_rows) < MAX_ROWS) ? cfg_q.image_rows : 7'(MAX_ROWS);
  assign cols  = (int'(cfg_q.image_cols) < MAX_COLS) ? cfg_q.image_cols : 7'(MAX_COLS);
  assign chans = (int'(cfg_q.channel_count) < CH_LIM) ? cfg_q.channel_count : 9'(CH_LIM);

  // Load: ternarize against the threshold
  assign s_ext = {sample_i[15], sample_i};
  assign t_pos = {2'b00, cfg_q.threshold};
  assign t_neg = -t_pos;

  assign ld_in_range = (7'(pixel_row_i) < rows) && (7'(pixel_col_i) < cols)
                    && (9'(channel_i) < chans);
  assign ld_addr = ADDR_W'((32'(pixel_row_i) * 32'(MAX_COLS) + 32'(pixel_col_i))
                   * 32'(MAX_BLOCKS) + 32'(channel_i[7:6]));

  // Read: stride, kernel offset and padding
  assign ph      = 10'(out_row_i) * 10'(cfg_q.row_stride) + 10'(kernel_row_i);
  assign pw      = 10'(out_col_i) * 10'(cfg_q.col_stride) + 10'(kernel_col_i);
  assign rows_hi = 10'(rows) + 10'(cfg_q.pad_rows);
  assign cols_hi = 10'(cols) + 10'(cfg_q.pad_cols);
  assign rd_pad  = (ph < 10'(cfg_q.pad_rows)) || (ph >= rows_hi)
                || (pw < 10'(cfg_q.pad_cols)) || (pw >= cols_hi);
  assign r_off   = ph - 10'(cfg_q.pad_rows);
  assign c_off   = pw - 10'(cfg_q.pad_cols);
  assign rd_addr = ADDR_W'((32'(r_off) * 32'(MAX_COLS) + 32'(c_off))
                   * 32'(MAX_BLOCKS) + 32'(block_i));

  // Blocks in use and the mask of the partial last block
  assign nblk      = 4'((10'(chans) + 10'd63) >> 6);
  assign blk_used  = 4'(block_i) < nblk;
  assign rem       = 10'(chans) - {2'b00, block_i, 6'b000000};
  assign part_mask = (rem >= 10'd64) ? '1 : ((64'(1) << rem[5:0]) - 64'(1));
  assign rd_use    = !rd_pad && blk_used;

  always_comb begin
    cmd_o  = '0;
    addr_o = '0;
    keep_o = 1'b1;
    if (req_type_i) begin
      cmd_o.op     = OP_READ;
      cmd_o.padded = rd_pad;
      cmd_o.mask   = rd_use ? part_mask : '0;
      addr_o       = rd_use ? rd_addr : '0;
    end else begin
      cmd_o.op      = OP_WRITE;
      cmd_o.nz_bit  = (s_ext > t_pos) || (s_ext < t_neg);
      cmd_o.neg_bit = s_ext < t_neg;
      cmd_o.mask    = 64'(1) << channel_i[5:0];
      addr_o        = ld_addr;
      // drop loads outside the sizes in use
      keep_o        = ld_in_range;
    end
  end

endmodule

// ===== src/tip_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tip_queue
// Short command queue that decouples the front classifier from the back end.
// ============================================================================
module tip_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = tip_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import tip_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q < CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/tip_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tip_back
// Owns the packed word store: clears it after reset, applies bit writes and
// serves word-pair reads through a registered read stage and output register.
// ============================================================================
module tip_back #(
  parameter int MAX_ROWS   = tip_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = tip_pkg::MAX_COLS_DEF,
  parameter int MAX_BLOCKS = tip_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_W     = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  tip_pkg::cmd_t                     pop_cmd_i,
  input  logic [ADDR_W-1:0]                 pop_addr_i,
  output logic                              init_done_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tip_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser
);
  import tip_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_BLOCKS;

  logic [WORD_BITS-1:0] neg_mem [DEPTH];
  logic [WORD_BITS-1:0] nz_mem  [DEPTH];

  logic                 clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0]    clr_addr_q, clr_addr_d;

  logic                 pop, rd_issue, wr_en, rd_adv;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_mask;
  logic                 wr_neg, wr_nz;

  logic [WORD_BITS-1:0] rdata_neg_q, rdata_nz_q;
  logic                 rd_v_q, rd_v_d;
  logic [WORD_BITS-1:0] rd_mask_q;
  logic                 rd_pad_q;

  logic                 out_v_q, out_v_d;
  logic [WORD_BITS-1:0] out_neg_q, out_nz_q;
  logic                 out_pad_q;

  // Read stage moves on when the output register is free or being taken
  assign rd_adv = rd_v_q && (!out_v_q || m_axis_tready);

  assign pop_ready_o = !clr_busy_q && ((pop_cmd_i.op == OP_WRITE) || !rd_v_q || rd_adv);
  assign pop         = pop_valid_i && pop_ready_o;
  assign rd_issue    = pop && (pop_cmd_i.op == OP_READ);
  assign init_done_o = !clr_busy_q;

  // Store write port: clearing sweep first, then bit writes
  assign wr_en   = clr_busy_q || (pop && (pop_cmd_i.op == OP_WRITE));
  assign wr_addr = clr_busy_q ? clr_addr_q : pop_addr_i;
  assign wr_mask = clr_busy_q ? '1 : pop_cmd_i.mask;
  assign wr_neg  = clr_busy_q ? 1'b0 : pop_cmd_i.neg_bit;
  assign wr_nz   = clr_busy_q ? 1'b0 : pop_cmd_i.nz_bit;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    rd_v_d = rd_v_q;
    if (rd_issue) begin
      rd_v_d = 1'b1;
    end else if (rd_adv) begin
      rd_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (rd_adv) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      rd_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      rd_v_q     <= rd_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // Word store, bit-masked write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (wr_mask[i]) begin
          neg_mem[wr_addr][i] <= wr_neg;
          nz_mem[wr_addr][i]  <= wr_nz;
        end
      end
    end
    if (rd_issue) begin
      rdata_neg_q <= neg_mem[pop_addr_i];
      rdata_nz_q  <= nz_mem[pop_addr_i];
    end
  end

  // Payload of the read stage and the output register
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_mask_q <= pop_cmd_i.mask;
      rd_pad_q  <= pop_cmd_i.padded;
    end
    if (rd_adv) begin
      out_neg_q <= rdata_neg_q & rd_mask_q;
      out_nz_q  <= rdata_nz_q & rd_mask_q;
      out_pad_q <= rd_pad_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_nz_q, out_neg_q};
  assign m_axis_tuser  = out_pad_q;

`ifndef ASSERT_OFF
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("store clearing pass restarted");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |=> rd_v_q)
    else $error("issued read lost before the read stage");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_pad_q) |-> ((out_neg_q == '0) && (out_nz_q == '0)))
    else $error("padded result carries non-zero words");
`endif

endmodule

// ===== src/ternarize_im2row_packer.sv =====
`timescale 1ns / 1ps
// Read path: a read beat passes the command queue, the read stage and the output register.
// Throughput: one beat per cycle, loads and reads alike, set by the single store ports,
// while the master side takes results. Reset: configuration returns to its defaults, then
// the store is swept to zero, one entry a cycle, MAX_ROWS*MAX_COLS*MAX_BLOCKS entries
// (16384 by default), with s_axis_tready low throughout; configuration writes are taken.
// ============================================================================
// ternarize_im2row_packer
// Ternarizes Q8.8 activations into packed 64-channel bit-pair words and
// serves im2row window reads with stride and zero padding.
// ============================================================================
module ternarize_im2row_packer #(
  parameter int MAX_ROWS   = tip_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = tip_pkg::MAX_COLS_DEF,
  parameter int MAX_BLOCKS = tip_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [tip_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tip_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: sample[15:0], pixel_row[21:16], pixel_col[27:22],
  // channel[35:28], out_row[42:36], out_col[49:43], kernel_row[53:50],
  // kernel_col[57:54], block[59:58], zero fill[63:60]
  input  logic [tip_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: req_type (0 load, 1 read)
  input  logic                              s_axis_tuser,
  // Master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: neg_word[63:0], nonzero_word[127:64]
  output logic [tip_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: padded
  output logic                              m_axis_tuser
);
  import tip_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_BLOCKS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W  = $bits(cmd_t);
  localparam int Q_W    = CMD_W + ADDR_W;

  cmd_t              f_cmd, b_cmd;
  logic [ADDR_W-1:0] f_addr, b_addr;
  logic              f_keep;
  logic              q_push_ready, q_pop_valid, q_pop_ready;
  logic [Q_W-1:0]    q_pop_data;
  logic              init_done;

  // Front: classify the beat against the configuration
  tip_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (s_axis_tuser),
    .sample_i     (s_axis_tdata[15:0]),
    .pixel_row_i  (s_axis_tdata[21:16]),
    .pixel_col_i  (s_axis_tdata[27:22]),
    .channel_i    (s_axis_tdata[35:28]),
    .out_row_i    (s_axis_tdata[42:36]),
    .out_col_i    (s_axis_tdata[49:43]),
    .kernel_row_i (s_axis_tdata[53:50]),
    .kernel_col_i (s_axis_tdata[57:54]),
    .block_i      (s_axis_tdata[59:58]),
    .cmd_o        (f_cmd),
    .addr_o       (f_addr),
    .keep_o       (f_keep)
  );

  // Hold the slave side while the store is being cleared or the queue is full;
  // dropped loads take no queue slot but still wait while the queue is full.
  assign s_axis_tready = q_push_ready && init_done;

  tip_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid && init_done && f_keep),
    .push_ready_o (q_push_ready),
    .push_data_i  ({f_addr, f_cmd}),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  assign b_cmd  = cmd_t'(q_pop_data[CMD_W-1:0]);
  assign b_addr = q_pop_data[Q_W-1:CMD_W];

  // Back: store writes, reads and the result register
  tip_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (q_pop_valid),
    .pop_ready_o   (q_pop_ready),
    .pop_cmd_i     (b_cmd),
    .pop_addr_i    (b_addr),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the ternarizing im2row packer. Drives load and
// window-read beats on the slave stream and keeps its own packed bit-pair
// store. Checks every window beat on the master stream against that store.
// Varies idling on both streams and the register settings between phases.
// ============================================================================
module tb_top;

  import tip_pkg::*;

  localparam int STORE_WORDS = MAX_ROWS_DEF * MAX_COLS_DEF * MAX_BLOCKS_DEF;
  localparam int ITEM_TARGET = 950;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;

  // Expected window beat: both packed words and the padding flag
  typedef struct packed {
    logic [WORD_BITS-1:0] neg;
    logic [WORD_BITS-1:0] nz;
    logic                 padded;
  } window_t;

  // --------------------------------------------------------------------------
  // Shadow of the packer: register copy, bit-pair store, windows still due
  // --------------------------------------------------------------------------
  class im2row_tracker;
    cfg_t                 setting;
    logic [WORD_BITS-1:0] neg_mem [STORE_WORDS];
    logic [WORD_BITS-1:0] nz_mem  [STORE_WORDS];
    window_t              windows_due [$];
    int errors, loads_kept, loads_dropped, reads_seen, padded_seen;

    function new();
      setting = CFG_RESET;
      foreach (neg_mem[i]) begin
        neg_mem[i] = '0;
        nz_mem[i]  = '0;
      end
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_THRESHOLD:     setting.threshold     = v[14:0];
        CFG_PAD_ROWS:      setting.pad_rows      = v[2:0];
        CFG_PAD_COLS:      setting.pad_cols      = v[2:0];
        CFG_ROW_STRIDE:    setting.row_stride    = v[2:0];
        CFG_COL_STRIDE:    setting.col_stride    = v[2:0];
        CFG_IMAGE_ROWS:    setting.image_rows    = v[6:0];
        CFG_IMAGE_COLS:    setting.image_cols    = v[6:0];
        CFG_CHANNEL_COUNT: setting.channel_count = v[8:0];
        default: ;
      endcase
    endfunction

    // Sizes in use, clipped to the store geometry
    function void used_sizes(output int rows, output int cols, output int chans);
      rows  = (int'(setting.image_rows) < MAX_ROWS_DEF) ? int'(setting.image_rows) :
              MAX_ROWS_DEF;
      cols  = (int'(setting.image_cols) < MAX_COLS_DEF) ? int'(setting.image_cols) :
              MAX_COLS_DEF;
      chans = (int'(setting.channel_count) < MAX_BLOCKS_DEF * WORD_BITS) ?
              int'(setting.channel_count) : MAX_BLOCKS_DEF * WORD_BITS;
    endfunction

    // Note one accepted slave beat; returns 0 when the packer ignores it
    function bit absorb_beat(logic user, logic [63:0] d);
      int rows, cols, chans, nblk, r, c, ch, ph, pw, b, rem, addr, smp, thr;
      int pr, pc;
      logic [WORD_BITS-1:0] one_hot, mask;
      window_t w;
      used_sizes(rows, cols, chans);
      nblk = (chans + WORD_BITS - 1) / WORD_BITS;
      if (user == OP_WRITE) begin
        smp = int'($signed(d[15:0]));
        thr = int'(setting.threshold);
        r   = int'(d[21:16]);
        c   = int'(d[27:22]);
        ch  = int'(d[35:28]);
        // Drop samples outside the image or the channels in use
        if (r >= rows || c >= cols || ch >= chans) begin
          loads_dropped++;
          return 0;
        end
        addr    = (r * MAX_COLS_DEF + c) * MAX_BLOCKS_DEF + ch / WORD_BITS;
        one_hot = 64'd1 << (ch % WORD_BITS);
        neg_mem[addr] &= ~one_hot;
        nz_mem[addr]  &= ~one_hot;
        if (smp > thr) begin
          nz_mem[addr] |= one_hot;
        end else if (smp < -thr) begin
          neg_mem[addr] |= one_hot;
          nz_mem[addr]  |= one_hot;
        end
        loads_kept++;
        return 1;
      end
      // Window read: stride first, then shift out the padding
      pr = int'(setting.pad_rows);
      pc = int'(setting.pad_cols);
      ph = int'(d[42:36]) * int'(setting.row_stride) + int'(d[53:50]);
      pw = int'(d[49:43]) * int'(setting.col_stride) + int'(d[57:54]);
      b  = int'(d[59:58]);
      w  = '0;
      if (ph < pr || ph >= rows + pr || pw < pc || pw >= cols + pc) begin
        w.padded = 1'b1;
        padded_seen++;
      end else if (b < nblk) begin
        addr  = ((ph - pr) * MAX_COLS_DEF + (pw - pc)) * MAX_BLOCKS_DEF + b;
        rem   = chans - b * WORD_BITS;
        mask  = (rem >= WORD_BITS) ? '1 : ((64'd1 << rem) - 64'd1);
        w.neg = neg_mem[addr] & mask;
        w.nz  = nz_mem[addr] & mask;
      end
      windows_due.push_back(w);
      reads_seen++;
      return 1;
    endfunction

    // Compare one master beat with the oldest window still due
    function void check_window(logic [OUT_DATA_W-1:0] d, logic pad);
      window_t w;
      if (windows_due.size() == 0) begin
        $error("window beat with nothing due: neg %h nonzero %h padded %b",
               d[63:0], d[127:64], pad);
        errors++;
        return;
      end
      w = windows_due.pop_front();
      if (d[63:0] !== w.neg) begin
        $error("neg_word: expected %h, got %h", w.neg, d[63:0]);
        errors++;
      end
      if (d[127:64] !== w.nz) begin
        $error("nonzero_word: expected %h, got %h", w.nz, d[127:64]);
        errors++;
      end
      if (pad !== w.padded) begin
        $error("padded: expected %b, got %b", w.padded, pad);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and shared bench state
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample, pixel_row, pixel_col, channel,
                                         // out_row, out_col, kernel_row,
                                         // kernel_col, block, zero fill
  logic                  s_axis_tuser;   // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // neg_word, nonzero_word
  logic                  m_axis_tuser;   // padded

  im2row_tracker tracker = new();

  int tx_idle_pct = 38;
  int rx_idle_pct = 65;
  int beats_counted = 0;
  int settings_used = 0;
  int hold_left = 0;
  int holds_done = 0;
  bit long_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  ternarize_im2row_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  // The hold is counted here so the sender keeps offering beats meanwhile.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD - 1;
      holds_done++;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every accepted master beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_window(m_axis_tdata, m_axis_tuser);
    end
  end

  // Hard stop in case the block wedges
  initial begin
    #1_000_000;
    $error("run did not complete in time");
    $display("ternarize_im2row_packer verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Beat builders and drivers
  // --------------------------------------------------------------------------
  function automatic cfg_t make_setting(int thr, int pr, int pc, int rs, int cs,
                                        int ir, int ic, int cc);
    cfg_t c;
    c.threshold     = thr[14:0];
    c.pad_rows      = pr[2:0];
    c.pad_cols      = pc[2:0];
    c.row_stride    = rs[2:0];
    c.col_stride    = cs[2:0];
    c.image_rows    = ir[6:0];
    c.image_cols    = ic[6:0];
    c.channel_count = cc[8:0];
    return c;
  endfunction

  function automatic logic [63:0] load_word(logic [63:0] base, int r, int c, int ch, int s);
    logic [63:0] d;
    d        = base;
    d[15:0]  = s[15:0];
    d[21:16] = r[5:0];
    d[27:22] = c[5:0];
    d[35:28] = ch[7:0];
    return d;
  endfunction

  function automatic logic [63:0] read_word(logic [63:0] base, int orow, int ocol,
                                            int kr, int kc, int b);
    logic [63:0] d;
    d        = base;
    d[42:36] = orow[6:0];
    d[49:43] = ocol[6:0];
    d[53:50] = kr[3:0];
    d[57:54] = kc[3:0];
    d[59:58] = b[1:0];
    return d;
  endfunction

  // Write every register; hold the enable high across the eight beats
  task automatic write_setting(input cfg_t c);
    cfg_idx_e idx;
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_THRESHOLD:     v = c.threshold;
        CFG_PAD_ROWS:      v = CFG_DATA_W'(c.pad_rows);
        CFG_PAD_COLS:      v = CFG_DATA_W'(c.pad_cols);
        CFG_ROW_STRIDE:    v = CFG_DATA_W'(c.row_stride);
        CFG_COL_STRIDE:    v = CFG_DATA_W'(c.col_stride);
        CFG_IMAGE_ROWS:    v = CFG_DATA_W'(c.image_rows);
        CFG_IMAGE_COLS:    v = CFG_DATA_W'(c.image_cols);
        default:           v = CFG_DATA_W'(c.channel_count);
      endcase
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= v;
      @(posedge clk_i);
      tracker.set_register(idx, v);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Offer one beat, idling first at the current rate; wait for acceptance
  task automatic send_beat(input logic user, input logic [63:0] d);
    if (beats_counted < ITEM_TARGET / 3) begin
      tx_idle_pct = 38;
      rx_idle_pct = 65;
    end else if (beats_counted < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 65;
      rx_idle_pct = 38;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= user;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(tracker.absorb_beat(user, d));
    beats_counted++;
  endtask

  // Drop valid, wait for every window due, then let trailing loads retire
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.windows_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (tracker.windows_due.size() != 0) begin
      $error("%0d window beats never arrived", tracker.windows_due.size());
      tracker.errors += tracker.windows_due.size();
      tracker.windows_due.delete();
    end
    repeat (6) @(posedge clk_i);
  endtask

  // Random beat shaped by the current setting: mostly loads inside the image
  // and reads aimed within or just past its padded area, the rest raw noise
  task automatic make_random_beat(output logic user, output logic [63:0] d);
    int rows, cols, chans, nblk, pick, t, s, tgt, kr, kc, orw, ocl, blk;
    cfg_t c;
    c = tracker.setting;
    tracker.used_sizes(rows, cols, chans);
    nblk = (chans + WORD_BITS - 1) / WORD_BITS;
    d = {$urandom, $urandom};
    d[63:60] = '0;
    user = OP_WRITE;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if (rows > 0 && cols > 0 && chans > 0) begin
        s = int'($signed(d[15:0]));
        t = int'(c.threshold);
        // Sit on the threshold edges a third of the time
        if ($urandom_range(2) == 0) begin
          case ($urandom_range(3))
            0:       s = t;
            1:       s = t + 1;
            2:       s = -t;
            default: s = -t - 1;
          endcase
        end
        d = load_word(d, $urandom_range(rows - 1), $urandom_range(cols - 1),
                      $urandom_range(chans - 1), s);
      end
    end else if (pick < 90 && pick >= 55) begin
      user = OP_READ;
      tgt  = $urandom_range(rows + 2 * int'(c.pad_rows));
      kr   = $urandom_range(tgt < 15 ? tgt : 15);
      if (c.row_stride == 0) orw = $urandom_range(127);
      else orw = (tgt - kr) / int'(c.row_stride);
      tgt  = $urandom_range(cols + 2 * int'(c.pad_cols));
      kc   = $urandom_range(tgt < 15 ? tgt : 15);
      if (c.col_stride == 0) ocl = $urandom_range(127);
      else ocl = (tgt - kc) / int'(c.col_stride);
      blk  = (nblk > 0 && $urandom_range(9) != 0) ? $urandom_range(nblk - 1) :
             $urandom_range(3);
      d    = read_word(d, orw > 127 ? 127 : orw, ocl > 127 ? 127 : ocl, kr, kc, blk);
    end else if (pick >= 90) begin
      user = OP_READ;
    end
  endtask

  task automatic run_phase(input cfg_t c, input int n);
    logic        user;
    logic [63:0] d;
    write_setting(c);
    // Ask for a long output hold-off while the sender runs flat out
    if (beats_counted >= 2 * ITEM_TARGET / 3 && holds_done < 2) long_hold_req = 1'b1;
    repeat (n) begin
      make_random_beat(user, d);
      send_beat(user, d);
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THRESHOLD;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: threshold 1.0, 200 channels so the last block is partial.
    // The store sweep after reset holds off the first beat.
    write_setting(make_setting(256, 0, 0, 1, 1, 64, 64, 200));
    send_beat(OP_WRITE, load_word('0, 0, 0, 0, 257));        // just above: +1
    send_beat(OP_WRITE, load_word('0, 0, 0, 1, 256));        // equal: 0
    send_beat(OP_WRITE, load_word('0, 0, 0, 2, -256));       // equal negative: 0
    send_beat(OP_WRITE, load_word('0, 0, 0, 3, -257));       // just below: -1
    send_beat(OP_WRITE, load_word('0, 0, 0, 63, 32767));
    send_beat(OP_WRITE, load_word('0, 0, 0, 64, -32768));
    send_beat(OP_WRITE, load_word('0, 63, 63, 199, -32768)); // top of partial block
    send_beat(OP_WRITE, load_word('0, 63, 63, 200, 32767));  // channel out of use
    send_beat(OP_WRITE, load_word('0, 63, 0, 128, 1000));
    send_beat(OP_WRITE, load_word('0, 0, 63, 127, -1000));
    send_beat(OP_READ, read_word('0, 0, 0, 0, 0, 0));
    send_beat(OP_READ, read_word('0, 0, 0, 0, 0, 1));
    send_beat(OP_READ, read_word('0, 63, 63, 0, 0, 3));
    send_beat(OP_READ, read_word('0, 63, 63, 0, 0, 2));
    send_beat(OP_READ, read_word('0, 48, 48, 15, 15, 3));    // kernel offset reach
    send_beat(OP_READ, read_word('0, 60, 0, 3, 0, 2));
    send_beat(OP_READ, read_word('0, 0, 63, 0, 0, 1));
    send_beat(OP_READ, read_word('0, 127, 0, 0, 0, 0));      // below the image
    send_beat(OP_READ, read_word('0, 0, 127, 0, 15, 0));     // right of the image
    send_beat(OP_WRITE, load_word('0, 0, 0, 0, -300));       // overwrite +1 with -1
    send_beat(OP_READ, read_word('0, 0, 0, 0, 0, 0));
    settle();

    // Corner settings: empty image, zero strides, oversized registers,
    // no channels, a single pixel, then a full-size open image
    run_phase(make_setting(100, 1, 1, 1, 1, 0, 5, 64), 30);
    run_phase(make_setting(64, 2, 1, 0, 0, 10, 10, 64), 60);
    run_phase(make_setting(32767, 7, 7, 7, 7, 127, 100, 511), 100);
    run_phase(make_setting(0, 0, 0, 1, 1, 8, 8, 0), 30);
    run_phase(make_setting(0, 0, 0, 1, 1, 1, 1, 1), 40);
    run_phase(make_setting($urandom_range(32767), 0, 0, 1, 1, 64, 64, 256), 60);

    // Random settings, small images mostly so loads cover the reads
    while (beats_counted < ITEM_TARGET) begin
      run_phase(make_setting($urandom_range(2) == 0 ? $urandom_range(32767) :
                             $urandom_range(600),
                             $urandom_range(7), $urandom_range(7),
                             $urandom_range(7, 1), $urandom_range(7, 1),
                             $urandom_range(9) == 0 ? 64 : $urandom_range(8, 1),
                             $urandom_range(9) == 0 ? 64 : $urandom_range(8, 1),
                             $urandom_range(256, 1)), 90);
    end

    $display("Run covered %0d stored loads, %0d ignored loads and %0d window reads",
             tracker.loads_kept, tracker.loads_dropped, tracker.reads_seen);
    $display("(%0d in padding) over %0d register settings and %0d long output holds.",
             tracker.padded_seen, settings_used, holds_done);
    if (tracker.errors == 0) begin
      $display("ternarize_im2row_packer verification clean");
    end else begin
      $display("ternarize_im2row_packer verification failed");
    end
    $finish;
  end

endmodule
